// ===== src/dqmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqmr_pkg
// Shared constants and types for the deque with match-remove.
// ----------------------------------------------------------------------------
package dqmr_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int OP_BITS       = 3;

    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_REMOVE     = 3'd4;
    localparam logic [OP_BITS-1:0] OP_FIND       = 3'd5;

    typedef struct packed {
        logic cmp;
        logic push_front;
        logic push_back;
        logic pop_front;
        logic rm;
        logic rd_front;
        logic rd_back;
        logic rd_match;
    } t_cell_ctl;

endpackage

// ===== src/deque_with_match_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_match_remove
// Bounded deque in a row of cells, position 0 at the front, with first-match
// find and order-keeping remove under a configurable compare mask.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  request  | start, busy             | i_opcode, i_operand_word
//  result   | o_strobe (1 cycle)      | o_result_word, o_found, o_full_error,
//           |                         | o_occupancy
//  config   | i_cfg_valid, o_cfg_ready| i_cfg_data (match mask)
//
// An item passes through a compare state, in which every cell compares, then
// an update state; the result strobes the cycle after the update. A new item
// is taken while idle or during the update state, before the last result strobes.
// Synchronous active-low reset empties the queue and sets the mask to all ones.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module deque_with_match_remove #(
    parameter int DEPTH     = dqmr_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dqmr_pkg::WORD_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dqmr_pkg::OP_BITS-1:0]  i_opcode,
    input  logic [WORD_BITS-1:0]          i_operand_word,
    output logic                          o_strobe,
    output logic [WORD_BITS-1:0]          o_result_word,
    output logic                          o_found,
    output logic                          o_full_error,
    output logic [CW-1:0]                 o_occupancy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [WORD_BITS-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state                        r_state;
    t_state                        n_state;
    logic [dqmr_pkg::OP_BITS-1:0]  r_op;
    logic [WORD_BITS-1:0]          r_word;
    logic [WORD_BITS-1:0]          r_mask;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_strobe;
    logic [WORD_BITS-1:0]          r_res;
    logic                          r_found;
    logic                          r_full;
    logic                          n_found;
    logic                          n_full;
    logic                          w_accept;
    logic                          w_upd;
    logic                          w_empty;
    logic                          w_is_full;
    dqmr_pkg::t_cell_ctl           w_ctl;

    logic [WORD_BITS-1:0] w_data [DEPTH];
    logic                 w_hit  [DEPTH+1];
    logic [WORD_BITS-1:0] w_acc  [DEPTH+1];

    assign busy        = (r_state == S_CMP);
    assign w_accept    = start && !busy;
    assign w_upd       = (r_state == S_UPD);
    assign w_empty     = (r_count == '0);
    assign w_is_full   = (r_count == FULL);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_ctl            = '0;
        w_ctl.cmp        = (r_state == S_CMP);
        w_ctl.push_front = w_upd && r_op == dqmr_pkg::OP_PUSH_FRONT && !w_is_full;
        w_ctl.push_back  = w_upd && r_op == dqmr_pkg::OP_PUSH_BACK && !w_is_full;
        w_ctl.pop_front  = w_upd && r_op == dqmr_pkg::OP_POP_FRONT && !w_empty;
        w_ctl.rm         = w_upd && r_op == dqmr_pkg::OP_REMOVE;
        w_ctl.rd_front   = w_upd && r_op == dqmr_pkg::OP_POP_FRONT;
        w_ctl.rd_back    = w_upd && r_op == dqmr_pkg::OP_POP_BACK;
        w_ctl.rd_match   = w_upd && (r_op == dqmr_pkg::OP_REMOVE
                                     || r_op == dqmr_pkg::OP_FIND);
    end

    assign w_hit[0] = 1'b0;
    assign w_acc[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dqmr_cell #(
            .IDX       (g),
            .DEPTH     (DEPTH),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_word    (r_word),
            .i_mask    (r_mask),
            .i_left    ((g == 0) ? r_word : w_data[(g == 0) ? 0 : g - 1]),
            .i_right   ((g == DEPTH - 1) ? w_data[g]
                                         : w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_hit_in  (w_hit[g]),
            .i_acc_in  (w_acc[g]),
            .o_data    (w_data[g]),
            .o_hit_out (w_hit[g+1]),
            .o_acc_out (w_acc[g+1])
        );
    end

    always_comb begin
        n_count = r_count;
        n_found = 1'b0;
        n_full  = 1'b0;
        case (r_op)
            dqmr_pkg::OP_PUSH_FRONT, dqmr_pkg::OP_PUSH_BACK: begin
                if (w_is_full) begin
                    n_full = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            dqmr_pkg::OP_POP_FRONT, dqmr_pkg::OP_POP_BACK: begin
                if (!w_empty) begin
                    n_found = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            dqmr_pkg::OP_REMOVE: begin
                if (w_hit[DEPTH]) begin
                    n_found = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            dqmr_pkg::OP_FIND: begin
                n_found = w_hit[DEPTH];
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = w_accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = w_accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mask   <= '1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_upd;
            if (w_upd) begin
                r_count <= n_count;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_opcode;
            r_word <= i_operand_word;
        end
        if (w_upd) begin
            r_res   <= w_acc[DEPTH];
            r_found <= n_found;
            r_full  <= n_full;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_result_word = r_res;
    assign o_found       = r_found;
    assign o_full_error  = r_full;
    assign o_occupancy   = r_count;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_strobe)
        else $error("accepted item gave no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("occupancy above depth");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_found && o_full_error))
        else $error("found and full_error together");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                            || r_count == $past(r_count) + 1'b1
                            || r_count == $past(r_count) - 1'b1))
        else $error("occupancy moved by more than one");
`endif

endmodule

// ===== src/dqmr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqmr_cell
// One queue position: holds a word, compares it to the key, shifts to or
// from its neighbors, and adds its word to the read chain when selected.
// ----------------------------------------------------------------------------
module dqmr_cell #(
    parameter int IDX       = 0,
    parameter int DEPTH     = dqmr_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dqmr_pkg::WORD_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  dqmr_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]         i_count,
    input  logic [WORD_BITS-1:0]  i_word,
    input  logic [WORD_BITS-1:0]  i_mask,
    input  logic [WORD_BITS-1:0]  i_left,
    input  logic [WORD_BITS-1:0]  i_right,
    input  logic                  i_hit_in,
    input  logic [WORD_BITS-1:0]  i_acc_in,
    output logic [WORD_BITS-1:0]  o_data,
    output logic                  o_hit_out,
    output logic [WORD_BITS-1:0]  o_acc_out
);

    localparam logic [CW-1:0] POS  = CW'(IDX);
    localparam logic [CW-1:0] POS1 = CW'(IDX + 1);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 r_match;
    logic                 w_valid;
    logic                 w_last;
    logic                 w_sel;

    assign w_valid   = POS < i_count;
    assign w_last    = POS1 == i_count;
    assign o_hit_out = i_hit_in | r_match;

    assign w_sel = (i_ctl.rd_front && IDX == 0 && w_valid)
                || (i_ctl.rd_back && w_last)
                || (i_ctl.rd_match && r_match && !i_hit_in);

    assign o_acc_out = i_acc_in | (w_sel ? r_data : '0);
    assign o_data    = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_front) begin
            n_data = i_left;
        end else if (i_ctl.push_back && POS == i_count) begin
            n_data = i_word;
        end else if (i_ctl.pop_front || (i_ctl.rm && o_hit_out)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.cmp) begin
            r_match <= w_valid && (((r_data ^ i_word) & i_mask) == '0);
        end
    end

endmodule
